### hdl/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// immediate implication checked on every clock edge outside reset
`define ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// non-overlapping implication: the consequent is checked in the cycle after the antecedent
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

### hdl/psd_pkg.sv
package psd_pkg;

	localparam int COORD_W = 16;
	localparam int DIFF_W  = COORD_W + 1;
	localparam int PROD_W  = 2 * DIFF_W;
	localparam int DIST_W  = 17;
	localparam int ROOT_BITS = DIST_W + 1;
	localparam int DEN_W   = 34;
	localparam int REM_W   = 68;
	localparam int QD_W    = DEN_W + ROOT_BITS;
	localparam int INC_W   = REM_W + 4;

	localparam logic [DIST_W-1:0] DIST_MAX = '1;

	localparam logic [1:0] KIND_PERP = 2'd0;
	localparam logic [1:0] KIND_B    = 2'd1;
	localparam logic [1:0] KIND_A    = 2'd2;

	// state of one square root step: remainder, q times denominator, root so far
	typedef struct packed {
		logic                 vld;
		logic [REM_W-1:0]     rem;
		logic [QD_W-1:0]      qd;
		logic [DEN_W-1:0]     den;
		logic [ROOT_BITS-1:0] root;
		logic [1:0]           kind;
		logic                 degen;
	} psd_root_t;

endpackage

### hdl/psd_in_if.sv
interface psd_in_if import psd_pkg::*; ;
	logic                      valid;
	logic                      ready;
	logic signed [COORD_W-1:0] ax;
	logic signed [COORD_W-1:0] ay;
	logic signed [COORD_W-1:0] bx;
	logic signed [COORD_W-1:0] by;
	logic signed [COORD_W-1:0] cx;
	logic signed [COORD_W-1:0] cy;
	logic                      segment_mode;

	modport source (output valid, ax, ay, bx, by, cx, cy, segment_mode, input ready);
	modport sink (input valid, ax, ay, bx, by, cx, cy, segment_mode, output ready);
endinterface

### hdl/psd_out_if.sv
interface psd_out_if import psd_pkg::*; ;
	logic              valid;
	logic              ready;
	logic [DIST_W-1:0] distance;
	logic [1:0]        nearest_kind;
	logic              degenerate;

	modport source (output valid, distance, nearest_kind, degenerate, input ready);
	modport sink (input valid, distance, nearest_kind, degenerate, output ready);
endinterface

### hdl/psd_root_stage.sv
module psd_root_stage import psd_pkg::*; #(
	parameter int BIT = 0
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      en,
	input  psd_root_t src,
	output psd_root_t dst
);

	logic [INC_W-1:0] inc;
	logic             take;

	// cost of setting this root bit: (2q*2^b + 2^2b) * den
	always_comb begin
		inc  = (INC_W'(src.qd) << (BIT + 1)) + (INC_W'(src.den) << (2 * BIT));
		take = inc <= INC_W'(src.rem);
	end

	// stage register, valid bit and payload move together
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dst <= '0;
		end else if (en) begin
			dst.vld   <= src.vld;
			dst.den   <= src.den;
			dst.kind  <= src.kind;
			dst.degen <= src.degen;
			if (take) begin
				dst.rem  <= src.rem - inc[REM_W-1:0];
				dst.qd   <= src.qd + (QD_W'(src.den) << BIT);
				dst.root <= src.root | (ROOT_BITS'(1) << BIT);
			end else begin
				dst.rem  <= src.rem;
				dst.qd   <= src.qd;
				dst.root <= src.root;
			end
		end
	end

endmodule

### hdl/point_segment_distance.sv
// point_segment_distance: distance from query point C to line or segment AB
//
// pts channel takes one query item (A, B, C in signed Q12.4 and segment_mode);
// res channel returns one item per query: distance (unsigned Q13.4, truncated,
// saturating), nearest_kind (perpendicular foot, endpoint B, endpoint A) and
// degenerate (A equals B, distance is then |AC|).
// Results leave in the order the queries came in.
// The pipeline has 23 register stages: five stages of differences, products,
// sums and selection, squaring of the cross product, then one stage per root
// bit for the 18-bit exact square root / quotient search.
// Throughput is one item per cycle while the receiver does not stall; the 18
// root stages each do one compare and subtract, so a new item enters every
// cycle unless the pipeline holds.
// Reset clears all stage valid bits; the pipeline is empty after reset.
// When the receiver stalls, the whole pipeline holds and pts.ready drops, so no
// item is lost or repeated; pts.ready stays high while the last stage is empty.
module point_segment_distance import psd_pkg::*; (
	input logic       clk,
	input logic       arst_n,
	psd_in_if.sink    pts,
	psd_out_if.source res
);

	`include "assert_macros.svh"

	logic en;
	psd_root_t root [ROOT_BITS+1];

	// global advance
	assign en        = !root[ROOT_BITS].vld || res.ready;
	assign pts.ready = en;

	// stage 1: coordinate differences
	logic vld_s1, seg_s1;
	logic signed [DIFF_W-1:0] abx_s1, aby_s1, acx_s1, acy_s1, bcx_s1, bcy_s1;

	// stage 2: products
	logic vld_s2, seg_s2, deg_s2;
	logic signed [PROD_W-1:0] pbx_s2, pby_s2, pax_s2, pay_s2, cr1_s2, cr2_s2;
	logic signed [PROD_W-1:0] sabx_s2, saby_s2, sacx_s2, sacy_s2, sbcx_s2, sbcy_s2;

	// stage 3: sums and case selection
	logic vld_s3, perp_s3, deg_s3;
	logic [1:0] kind_s3;
	logic [DEN_W-1:0] c_s3, l2_s3, len_s3;

	// stage 4: partial squares of the cross product
	logic vld_s4, perp_s4, deg_s4;
	logic [1:0] kind_s4;
	logic [DEN_W-1:0] hh_s4, hl_s4, ll_s4, l2_s4, len_s4;

	// stage 3 combinational
	logic signed [PROD_W:0] dot_b, dot_a, crs_c;
	logic [PROD_W:0] cross_abs;
	logic [DEN_W-1:0] l2_c, la_c, lb_c;

	always_comb begin
		dot_b = {pbx_s2[PROD_W-1], pbx_s2} + {pby_s2[PROD_W-1], pby_s2};
		dot_a = {pax_s2[PROD_W-1], pax_s2} + {pay_s2[PROD_W-1], pay_s2};
		crs_c = {cr1_s2[PROD_W-1], cr1_s2} - {cr2_s2[PROD_W-1], cr2_s2};
		cross_abs = crs_c[PROD_W] ? -crs_c : crs_c;
		l2_c = DEN_W'(sabx_s2[PROD_W-2:0]) + DEN_W'(saby_s2[PROD_W-2:0]);
		la_c = DEN_W'(sacx_s2[PROD_W-2:0]) + DEN_W'(sacy_s2[PROD_W-2:0]);
		lb_c = DEN_W'(sbcx_s2[PROD_W-2:0]) + DEN_W'(sbcy_s2[PROD_W-2:0]);
	end

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else if (en) begin
			vld_s1 <= pts.valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
		end
	end

	// front stages payload
	always_ff @(posedge clk) begin
		if (en) begin
			seg_s1 <= pts.segment_mode;
			abx_s1 <= {pts.bx[COORD_W-1], pts.bx} - {pts.ax[COORD_W-1], pts.ax};
			aby_s1 <= {pts.by[COORD_W-1], pts.by} - {pts.ay[COORD_W-1], pts.ay};
			acx_s1 <= {pts.cx[COORD_W-1], pts.cx} - {pts.ax[COORD_W-1], pts.ax};
			acy_s1 <= {pts.cy[COORD_W-1], pts.cy} - {pts.ay[COORD_W-1], pts.ay};
			bcx_s1 <= {pts.cx[COORD_W-1], pts.cx} - {pts.bx[COORD_W-1], pts.bx};
			bcy_s1 <= {pts.cy[COORD_W-1], pts.cy} - {pts.by[COORD_W-1], pts.by};

			seg_s2  <= seg_s1;
			deg_s2  <= (abx_s1 == '0) && (aby_s1 == '0);
			pbx_s2  <= PROD_W'(abx_s1) * PROD_W'(bcx_s1);
			pby_s2  <= PROD_W'(aby_s1) * PROD_W'(bcy_s1);
			pax_s2  <= PROD_W'(abx_s1) * PROD_W'(acx_s1);
			pay_s2  <= PROD_W'(aby_s1) * PROD_W'(acy_s1);
			cr1_s2  <= PROD_W'(abx_s1) * PROD_W'(acy_s1);
			cr2_s2  <= PROD_W'(aby_s1) * PROD_W'(acx_s1);
			sabx_s2 <= PROD_W'(abx_s1) * PROD_W'(abx_s1);
			saby_s2 <= PROD_W'(aby_s1) * PROD_W'(aby_s1);
			sacx_s2 <= PROD_W'(acx_s1) * PROD_W'(acx_s1);
			sacy_s2 <= PROD_W'(acy_s1) * PROD_W'(acy_s1);
			sbcx_s2 <= PROD_W'(bcx_s1) * PROD_W'(bcx_s1);
			sbcy_s2 <= PROD_W'(bcy_s1) * PROD_W'(bcy_s1);

			deg_s3 <= deg_s2;
			c_s3   <= cross_abs[DEN_W-1:0];
			l2_s3  <= l2_c;
			if (deg_s2) begin
				kind_s3 <= KIND_A;
				perp_s3 <= 1'b0;
				len_s3  <= la_c;
			end else if (seg_s2 && (dot_b > 0)) begin
				kind_s3 <= KIND_B;
				perp_s3 <= 1'b0;
				len_s3  <= lb_c;
			end else if (seg_s2 && (dot_a < 0)) begin
				kind_s3 <= KIND_A;
				perp_s3 <= 1'b0;
				len_s3  <= la_c;
			end else begin
				kind_s3 <= KIND_PERP;
				perp_s3 <= 1'b1;
				len_s3  <= la_c;
			end

			deg_s4  <= deg_s3;
			kind_s4 <= kind_s3;
			perp_s4 <= perp_s3;
			l2_s4   <= l2_s3;
			len_s4  <= len_s3;
			hh_s4   <= DEN_W'(c_s3[DEN_W-1:DEN_W/2]) * DEN_W'(c_s3[DEN_W-1:DEN_W/2]);
			hl_s4   <= DEN_W'(c_s3[DEN_W-1:DEN_W/2]) * DEN_W'(c_s3[DEN_W/2-1:0]);
			ll_s4   <= DEN_W'(c_s3[DEN_W/2-1:0]) * DEN_W'(c_s3[DEN_W/2-1:0]);
		end
	end

	// stage 5: numerator and denominator of the root search
	logic [REM_W-1:0] csq;

	always_comb begin
		csq = {hh_s4, {DEN_W{1'b0}}} + (REM_W'(hl_s4) << (DEN_W/2 + 1)) + REM_W'(ll_s4);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			root[0] <= '0;
		end else if (en) begin
			root[0].vld   <= vld_s4;
			root[0].rem   <= perp_s4 ? csq : REM_W'(len_s4);
			root[0].den   <= perp_s4 ? l2_s4 : DEN_W'(1);
			root[0].qd    <= '0;
			root[0].root  <= '0;
			root[0].kind  <= kind_s4;
			root[0].degen <= deg_s4;
		end
	end

	// one root bit per stage, most significant first
	for (genvar i = 0; i < ROOT_BITS; i++) begin : g_root
		psd_root_stage #(
			.BIT(ROOT_BITS - 1 - i)
		) u_stage (
			.clk   (clk),
			.arst_n(arst_n),
			.en    (en),
			.src   (root[i]),
			.dst   (root[i+1])
		);
	end

	// result with saturation
	assign res.valid        = root[ROOT_BITS].vld;
	assign res.distance     = root[ROOT_BITS].root[ROOT_BITS-1] ? DIST_MAX
		: root[ROOT_BITS].root[DIST_W-1:0];
	assign res.nearest_kind = root[ROOT_BITS].kind;
	assign res.degenerate   = root[ROOT_BITS].degen;

	`ASSERT_NOW(a_degen_kind, clk, arst_n, res.valid && res.degenerate, res.nearest_kind == KIND_A)
	`ASSERT_NOW(a_stall_ready, clk, arst_n, res.valid && !res.ready, !pts.ready)
	`ASSERT_NEXT(a_perp_den, clk, arst_n, en && vld_s4 && !perp_s4, root[0].den == DEN_W'(1))

endmodule
